// File: src/efm_pkg.sv
// ----------------------------------------------------------------------------
// efm_pkg
// types, constants and the fractional exponent table for the membership block
// ----------------------------------------------------------------------------
`default_nettype none
package efm_pkg;

  localparam int unsigned MaxCenters = 16;
  localparam int unsigned IdxW       = $clog2(MaxCenters);
  localparam int unsigned CntW       = $clog2(MaxCenters + 1);
  localparam logic [16:0] Log2eQ16   = 17'd94548;
  localparam logic [31:0] StepQ32    = 32'd4283353945;
  localparam logic [15:0] LambdaRst  = 16'd256;
  localparam logic [16:0] OneQ15     = 17'd32768;

  typedef struct packed {
    logic [31:0] dissimilarity;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [15:0] membership;
    logic [3:0]  center_index;
    logic        last_res;
  } out_word_t;

  // 2^(-f/256) in Q16 for every f, built by repeated multiplication at elaboration
  function automatic logic [255:0][16:0] frac_table();
    logic [255:0][16:0] t;
    logic [63:0] acc;
    logic [63:0] rnd;
    acc = 64'd1 << 32;
    for (int f = 0; f < 256; f++) begin
      rnd  = (acc + 64'h8000) >> 16;
      t[f] = rnd[16:0];
      acc  = (acc * {32'd0, StepQ32} + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam logic [255:0][16:0] FracTab = frac_table();

endpackage
`default_nettype wire

// File: src/efm_div.sv
// ----------------------------------------------------------------------------
// efm_div
// restoring divider, one quotient bit per cycle, 32-bit dividend and divisor
// ----------------------------------------------------------------------------
`default_nettype none
module efm_div import efm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);

  logic [31:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quot_q[31]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// File: src/entropy_fuzzy_membership.sv
// ----------------------------------------------------------------------------
// entropy_fuzzy_membership
// entropy-regularized fuzzy c-means membership of one point
// ----------------------------------------------------------------------------
// in channel: one word per center, dissimilarity (Q16.16) and a last flag.
// while idle a word is accepted every cycle, a word without last is stored
// at once. on last the block stalls its input and emits one membership word
// per stored center (Q1.15, with center index and last_res on the final one).
// zero case: one share divide, then one word per cycle while out stall is low.
// softmax case: a first pass sums the exponents of all entries (read, two
// multiplies, table, shift), then per entry the weight is redone, divided
// in the shared bit-serial divider and emitted.
// a clear state then empties the point before the input is free again.
// the single output register holds a word while out stall is high; the
// sequencer waits on it. cfg lambda (Q8.8, reset 1.0) is written any
// time the channel is ready, intended between points.
// reset empties the point and sets lambda to 1.0; the store itself is
// not cleared, entries are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none
module entropy_fuzzy_membership import efm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_ZDIV, S_ZWAIT, S_ZEMIT,
    S_W0, S_W1, S_W2, S_W3, S_DIV, S_DWAIT, S_EMIT, S_CLEAR
  } state_e;

  state_e        state_q;
  logic [31:0]   store_q [MaxCenters];
  logic [CntW-1:0] count_q, zeros_q, idx_q;
  logic [31:0]   min_q;
  logic [15:0]   lambda_q;
  logic          pass_q;      // 0 = summing, 1 = dividing
  logic [31:0]   sum_q;
  logic [31:0]   rd_q;
  logic [47:0]   x8_q;
  logic [39:0]   y_q;
  logic [16:0]   e_q;
  logic [31:0]   share_q;
  logic          ov_q;
  out_word_t     od_q;

  logic          div_start, div_done;
  logic [31:0]   div_num, div_den, div_quot;
  logic          accept;
  logic          emit;
  logic [47:0]   prod1;
  logic [63:0]   prod2;
  logic [16:0]   tab;
  logic [IdxW-1:0] rix;
  logic          last_idx;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign rix         = idx_q[IdxW-1:0];
  assign last_idx    = (idx_q + 1'b1 == count_q);
  assign emit        = ((state_q == S_ZEMIT) || (state_q == S_EMIT)) &&
                       (!ov_q || !out_stall_i);

  assign prod1 = {16'd0, rd_q - min_q} * {32'd0, lambda_q};
  assign prod2 = {16'd0, x8_q} * {47'd0, Log2eQ16};
  assign tab   = FracTab[y_q[7:0]];

  assign div_start = (state_q == S_ZDIV) || (state_q == S_DIV);
  assign div_num   = (state_q == S_ZDIV) ? {15'd0, OneQ15} : {e_q, 15'd0};
  assign div_den   = (state_q == S_ZDIV) ? {{(32-CntW){1'b0}}, zeros_q} : sum_q;

  efm_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (accept && count_q < CntW'(MaxCenters)) begin
      store_q[count_q[IdxW-1:0]] <= in_data_i.dissimilarity;
    end
    rd_q <= store_q[rix];
    x8_q <= {16'd0, prod1[47:16]};
    y_q  <= prod2[55:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      zeros_q  <= '0;
      idx_q    <= '0;
      min_q    <= '1;
      lambda_q <= LambdaRst;
      pass_q   <= 1'b0;
      sum_q    <= '0;
      e_q      <= '0;
      share_q  <= '0;
      ov_q     <= 1'b0;
      od_q     <= '0;
    end else begin
      if (emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) lambda_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (count_q < CntW'(MaxCenters)) begin
              count_q <= count_q + 1'b1;
              if (in_data_i.dissimilarity == '0) zeros_q <= zeros_q + 1'b1;
              if (in_data_i.dissimilarity < min_q) min_q <= in_data_i.dissimilarity;
            end
            if (in_data_i.last) begin
              idx_q  <= '0;
              pass_q <= 1'b0;
              sum_q  <= '0;
              // a word dropped on a full store does not count as a zero
              if ((in_data_i.dissimilarity == '0 && count_q < CntW'(MaxCenters)) ||
                  zeros_q != '0) begin
                state_q <= S_ZDIV;
              end else begin
                state_q <= S_W0;
              end
            end
          end
        end
        S_ZDIV: state_q <= S_ZWAIT;
        S_ZWAIT: begin
          if (div_done) begin
            share_q <= div_quot;
            state_q <= S_ZEMIT;
          end
        end
        S_ZEMIT: begin
          if (emit) begin
            od_q.membership   <= (store_q[rix] == '0) ? share_q[15:0] : 16'd0;
            od_q.center_index <= 4'(idx_q);
            od_q.last_res     <= last_idx;
            idx_q <= idx_q + 1'b1;
            if (last_idx) state_q <= S_CLEAR;
          end
        end
        S_W0: state_q <= S_W1;    // rd_q loads
        S_W1: state_q <= S_W2;    // x8 loads
        S_W2: state_q <= S_W3;    // y loads
        S_W3: begin
          if (y_q[39:8] >= 32'd17) begin
            e_q <= '0;
          end else begin
            e_q <= tab >> y_q[12:8];
          end
          if (!pass_q) begin
            sum_q <= sum_q + {15'd0, ((y_q[39:8] >= 32'd17) ? 17'd0 : (tab >> y_q[12:8]))};
            if (last_idx) begin
              pass_q <= 1'b1;
              idx_q  <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
            state_q <= S_W0;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: state_q <= S_DWAIT;
        S_DWAIT: if (div_done) state_q <= S_EMIT;
        S_EMIT: begin
          if (emit) begin
            od_q.membership   <= div_quot[15:0];
            od_q.center_index <= 4'(idx_q);
            od_q.last_res     <= last_idx;
            idx_q <= idx_q + 1'b1;
            state_q <= last_idx ? S_CLEAR : S_W0;
          end
        end
        S_CLEAR: begin
          count_q <= '0;
          zeros_q <= '0;
          min_q   <= '1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
